@@ rtl/core/lsp_pkg.sv @@
// Shared constants, register codes and types of the looped sample player.
// No dependencies; the files that use this package refer to it by scoped names.
package lsp_pkg;

  // Store depths
  localparam int MAIN_FRAMES_MAX     = 16384;
  localparam int ONE_SHOT_FRAMES_MAX = 8192;

  // Derived widths: address, frame count, phase and phase sum
  localparam int MAIN_AW = $clog2(MAIN_FRAMES_MAX);
  localparam int MAIN_CW = MAIN_AW + 1;
  localparam int MPH_W   = MAIN_AW + 32;
  localparam int MSUM_W  = MPH_W + 1;
  localparam int OS_AW   = $clog2(ONE_SHOT_FRAMES_MAX);
  localparam int OS_CW   = OS_AW + 1;
  localparam int OPH_W   = OS_AW + 33;

  localparam int FRAME_W   = 16;
  localparam int CFG_IDX_W = 3;

  // Input modes
  localparam logic [1:0] MODE_TICK     = 2'd0;
  localparam logic [1:0] MODE_MAIN_WR  = 2'd1;
  localparam logic [1:0] MODE_OS_WR    = 2'd2;

  // Switch positions
  localparam logic [1:0] SW_UP   = 2'd0;
  localparam logic [1:0] SW_MID  = 2'd1;
  localparam logic [1:0] SW_DOWN = 2'd2;
  localparam logic [1:0] SW_NONE = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_FRAMES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OS_FRAMES   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OS_STEP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_COUNT  = 3'd4;

  // Reset values
  localparam logic [31:0] MAIN_STEP_RST  = 32'h8000_0000;
  localparam logic [31:0] OS_STEP_RST    = 32'h4000_0000;
  localparam logic [3:0]  LOOP_COUNT_RST = 4'd3;

  // Saturation limits (14-bit working width)
  localparam logic signed [13:0] SAT_HI = 14'sd2047;
  localparam logic signed [13:0] SAT_LO = -14'sd2048;

  // Configuration as seen by the player, already saturated
  typedef struct packed {
    logic [MAIN_CW-1:0] main_frames;
    logic [OS_CW-1:0]   os_frames;
    logic [31:0]        main_step;
    logic [31:0]        os_step;
    logic [3:0]         loops_eff;
  } lsp_cfg_t;

endpackage

@@ rtl/core/lsp_in_if.sv @@
// Input channel: tick and frame-write words.
// No package dependency; field widths are fixed here.
interface lsp_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [1:0]        switch_pos;
  logic [13:0]       frame_address;
  logic signed [7:0] left_byte;
  logic signed [7:0] right_byte;

  modport source (output valid, mode, switch_pos, frame_address, left_byte, right_byte,
                  input ready);
  modport sink   (input valid, mode, switch_pos, frame_address, left_byte, right_byte,
                  output ready);
endinterface

@@ rtl/core/lsp_out_if.sv @@
// Result channel: one output word per tick.
// Standalone; no package dependency.
interface lsp_out_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] left_out;
  logic signed [11:0] right_out;
  logic               running;
  logic [3:0]         loops_left;

  modport source (output valid, left_out, right_out, running, loops_left, input ready);
  modport sink   (input valid, left_out, right_out, running, loops_left, output ready);
endinterface

@@ rtl/core/lsp_cfg_if.sv @@
// Configuration write channel: register index and write data.
// Index width from lsp_pkg.
interface lsp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lsp_pkg::CFG_IDX_W-1:0]  index;
  logic [31:0]                    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/lsp_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies. Read returns the old contents on a same-address write.
module lsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/lsp_cfg_regs.sv @@
// Configuration register bank; saturates frame counts and loop count.
// Depends on lsp_pkg and lsp_cfg_if.
module lsp_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  lsp_cfg_if.sink           cfg_ch,
  output lsp_pkg::lsp_cfg_t cfg_o
);

  logic [14:0] main_frames_r;
  logic [13:0] os_frames_r;
  logic [31:0] main_step_r;
  logic [31:0] os_step_r;
  logic [3:0]  loop_count_r;

  // The user must send writes only while idle; the block does not enforce it. The port never stalls
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_frames_r <= '0;
      os_frames_r   <= '0;
      main_step_r   <= lsp_pkg::MAIN_STEP_RST;
      os_step_r     <= lsp_pkg::OS_STEP_RST;
      loop_count_r  <= lsp_pkg::LOOP_COUNT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        lsp_pkg::CFG_MAIN_FRAMES: main_frames_r <= cfg_ch.data[14:0];
        lsp_pkg::CFG_OS_FRAMES:   os_frames_r   <= cfg_ch.data[13:0];
        lsp_pkg::CFG_MAIN_STEP:   main_step_r   <= cfg_ch.data;
        lsp_pkg::CFG_OS_STEP:     os_step_r     <= cfg_ch.data;
        lsp_pkg::CFG_LOOP_COUNT:  loop_count_r  <= cfg_ch.data[3:0];
        default: ;
      endcase
    end
  end

  // Frame counts clip to store depth; a loop count of zero plays once
  always_comb begin
    cfg_o.main_frames = (32'(main_frames_r) > lsp_pkg::MAIN_FRAMES_MAX) ?
                        lsp_pkg::MAIN_CW'(lsp_pkg::MAIN_FRAMES_MAX) :
                        lsp_pkg::MAIN_CW'(main_frames_r);
    cfg_o.os_frames   = (32'(os_frames_r) > lsp_pkg::ONE_SHOT_FRAMES_MAX) ?
                        lsp_pkg::OS_CW'(lsp_pkg::ONE_SHOT_FRAMES_MAX) :
                        lsp_pkg::OS_CW'(os_frames_r);
    cfg_o.main_step   = main_step_r;
    cfg_o.os_step     = os_step_r;
    cfg_o.loops_eff   = (loop_count_r == 4'd0) ? 4'd1 : loop_count_r;
  end

endmodule

@@ rtl/core/lsp_mix.sv @@
// Linear interpolation of both voices and the saturated stereo sum.
// Depends on lsp_pkg for frame width and saturation limits.
module lsp_mix (
  input  logic [lsp_pkg::FRAME_W-1:0] main_a,
  input  logic [lsp_pkg::FRAME_W-1:0] main_b,
  input  logic [11:0]                 main_frac,
  input  logic                        main_on,
  input  logic [lsp_pkg::FRAME_W-1:0] os_a,
  input  logic [lsp_pkg::FRAME_W-1:0] os_b,
  input  logic [11:0]                 os_frac,
  input  logic                        os_on,
  input  logic                        perf,
  output logic signed [11:0]          mix_left,
  output logic signed [11:0]          mix_right
);

  function automatic logic signed [11:0] sat12(input logic signed [13:0] v);
    if (v > lsp_pkg::SAT_HI) return 12'(lsp_pkg::SAT_HI);
    if (v < lsp_pkg::SAT_LO) return 12'(lsp_pkg::SAT_LO);
    return 12'(v);
  endfunction

  // a*16 + floor((b - a) * frac / 256); one 8-bit step is 16 output units
  function automatic logic signed [11:0] lerp(input logic [7:0] a, input logic [7:0] b,
                                              input logic [11:0] f);
    logic signed [8:0]  d;
    logic signed [21:0] p;
    logic signed [13:0] base;
    d    = $signed({b[7], b}) - $signed({a[7], a});
    p    = d * $signed({1'b0, f});
    base = $signed({{2{a[7]}}, a, 4'b0000});
    return sat12(base + 14'(p >>> 8));
  endfunction

  logic signed [11:0] ml, mr, ol, orr;

  // Per-voice samples, silent when the voice does not play
  always_comb begin
    ml  = main_on ? lerp(main_a[7:0],  main_b[7:0],  main_frac) : 12'sd0;
    mr  = main_on ? lerp(main_a[15:8], main_b[15:8], main_frac) : 12'sd0;
    ol  = os_on   ? lerp(os_a[7:0],    os_b[7:0],    os_frac)   : 12'sd0;
    orr = os_on   ? lerp(os_a[15:8],   os_b[15:8],   os_frac)   : 12'sd0;
  end

  // Output only during a performance
  assign mix_left  = perf ? sat12(14'(ml) + 14'(ol))  : 12'sd0;
  assign mix_right = perf ? sat12(14'(mr) + 14'(orr)) : 12'sd0;

endmodule

@@ rtl/core/looped_sample_player_with_one_shot.sv @@
// Looped sample player with one-shot voice. An accepted tick word steps through
// RD_A and RD_B, the two reads (frame and next frame) on each store's single read
// port, and DONE, which writes its result to the output register and which a
// stalled output register stretches. A new tick is taken only in IDLE.
// Frame-write words are taken every cycle except the first read cycle of a tick.
// Reset (rst_n, synchronous, active low) clears phases, performance state and
// the output valid flag; the frame stores and output data are not cleared.
module looped_sample_player_with_one_shot (
  input  logic       clk,
  input  logic       rst_n,
  lsp_in_if.sink     in_ch,
  lsp_out_if.source  out_ch,
  lsp_cfg_if.sink    cfg_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD_A = 2'd1;
  localparam logic [1:0] ST_RD_B = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  lsp_pkg::lsp_cfg_t cfg;

  lsp_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg_o  (cfg)
  );

  // Sequencer and voice state
  logic [1:0]                   state_r;
  logic [lsp_pkg::MPH_W-1:0]    mph_r;
  logic [lsp_pkg::OPH_W-1:0]    oph_r;
  logic                         os_act_r, os_play_r, main_on_r, perf_r;
  logic [3:0]                   loops_r;
  logic [1:0]                   prev_sw_r;
  logic [lsp_pkg::FRAME_W-1:0]  main_a_r, os_a_r;

  // Output register
  logic                         out_valid_r;
  logic signed [11:0]           left_r, right_r;
  logic                         running_r;
  logic [3:0]                   loops_out_r;

  // Handshakes; writes pause in RD_A so the next-frame read never sees a newer word
  logic in_fire, tick_fire, wr_main, wr_os, done_fire;
  assign in_ch.ready = (state_r == ST_IDLE) ||
                       ((in_ch.mode != lsp_pkg::MODE_TICK) && (state_r != ST_RD_A));
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign tick_fire   = in_fire && (in_ch.mode == lsp_pkg::MODE_TICK);
  assign wr_main     = in_fire && (in_ch.mode == lsp_pkg::MODE_MAIN_WR) &&
                       (32'(in_ch.frame_address) < lsp_pkg::MAIN_FRAMES_MAX);
  assign wr_os       = in_fire && (in_ch.mode == lsp_pkg::MODE_OS_WR) &&
                       (32'(in_ch.frame_address) < lsp_pkg::ONE_SHOT_FRAMES_MAX);
  assign done_fire   = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  // Tick entry: switch edges, end-of-loop check, one-shot trigger
  logic [1:0]                sw;
  logic                      sw_reset, sw_start, os_trig, os_play0;
  logic                      perf0;
  logic [3:0]                loops0;
  logic [lsp_pkg::MPH_W-1:0] mph0;
  logic [lsp_pkg::OPH_W-1:0] oph0;

  always_comb begin
    sw       = (in_ch.switch_pos == lsp_pkg::SW_NONE) ? prev_sw_r : in_ch.switch_pos;
    sw_reset = (sw == lsp_pkg::SW_UP) && (prev_sw_r != lsp_pkg::SW_UP);
    sw_start = !sw_reset && (sw == lsp_pkg::SW_MID) && (prev_sw_r != lsp_pkg::SW_MID) &&
               !perf_r && (loops_r == cfg.loops_eff);
    perf0    = sw_reset ? 1'b0 : (sw_start ? 1'b1 : perf_r);
    loops0   = (sw_reset || sw_start) ? cfg.loops_eff : loops_r;
    mph0     = (sw_reset || sw_start) ? '0 : mph_r;
    if ((cfg.main_frames != '0) &&
        ({1'b0, mph0[lsp_pkg::MPH_W-1:32]} >= cfg.main_frames)) begin
      mph0 = '0;
    end
    os_trig  = (sw == lsp_pkg::SW_DOWN) && (prev_sw_r != lsp_pkg::SW_DOWN);
    oph0     = os_trig ? '0 : oph_r;
    os_play0 = (os_trig || os_act_r) && (oph0[lsp_pkg::OPH_W-1:32] < cfg.os_frames);
  end

  // Read addresses: current frame in RD_A, next frame in RD_B
  logic [lsp_pkg::MAIN_AW-1:0] m_idx, m_raddr;
  logic [lsp_pkg::MAIN_CW-1:0] m_inc;
  logic [lsp_pkg::OS_AW-1:0]   o_idx, o_raddr;
  logic [lsp_pkg::OS_CW-1:0]   o_inc;
  logic                        ram_re;

  always_comb begin
    m_idx   = mph_r[lsp_pkg::MPH_W-1:32];
    m_inc   = {1'b0, m_idx} + 1'b1;
    o_idx   = oph_r[lsp_pkg::OS_AW+31:32];
    o_inc   = {1'b0, o_idx} + 1'b1;
    m_raddr = m_idx;
    o_raddr = o_idx;
    if (state_r == ST_RD_B) begin
      m_raddr = (m_inc == cfg.main_frames) ? '0 : m_inc[lsp_pkg::MAIN_AW-1:0];
      o_raddr = (o_inc < cfg.os_frames) ? o_inc[lsp_pkg::OS_AW-1:0] : o_idx;
    end
    ram_re  = (state_r == ST_RD_A) || (state_r == ST_RD_B);
  end

  logic [lsp_pkg::FRAME_W-1:0] main_rdata, os_rdata;

  lsp_ram #(.WIDTH(lsp_pkg::FRAME_W), .DEPTH(lsp_pkg::MAIN_FRAMES_MAX)) u_main_ram (
    .clk   (clk),
    .we    (wr_main),
    .waddr (lsp_pkg::MAIN_AW'(in_ch.frame_address)),
    .wdata ({in_ch.right_byte, in_ch.left_byte}),
    .re    (ram_re),
    .raddr (m_raddr),
    .rdata (main_rdata)
  );

  lsp_ram #(.WIDTH(lsp_pkg::FRAME_W), .DEPTH(lsp_pkg::ONE_SHOT_FRAMES_MAX)) u_os_ram (
    .clk   (clk),
    .we    (wr_os),
    .waddr (lsp_pkg::OS_AW'(in_ch.frame_address)),
    .wdata ({in_ch.right_byte, in_ch.left_byte}),
    .re    (ram_re),
    .raddr (o_raddr),
    .rdata (os_rdata)
  );

  // Tick completion: main and one-shot phase advance, loop wrap, loop count
  logic [lsp_pkg::MSUM_W-1:0]  msum;
  logic [lsp_pkg::MAIN_CW-1:0] mwrap_hi;
  logic [lsp_pkg::MPH_W-1:0]   mph_nxt;
  logic [3:0]                  loops_nxt, loops_dec;
  logic                        perf_nxt;
  logic [lsp_pkg::OPH_W-1:0]   oph_nxt;

  always_comb begin
    msum      = {1'b0, mph_r} + lsp_pkg::MSUM_W'(cfg.main_step);
    mwrap_hi  = msum[lsp_pkg::MSUM_W-1:32] - cfg.main_frames;
    loops_dec = loops_r - 4'd1;
    mph_nxt   = mph_r;
    loops_nxt = loops_r;
    perf_nxt  = perf_r;
    if (main_on_r) begin
      mph_nxt = msum[lsp_pkg::MPH_W-1:0];
      if (msum[lsp_pkg::MSUM_W-1:32] >= cfg.main_frames) begin
        mph_nxt = lsp_pkg::MPH_W'({mwrap_hi, msum[31:0]});
        if (perf_r && (loops_r != 4'd0)) begin
          loops_nxt = loops_dec;
          if (loops_dec == 4'd0) begin
            perf_nxt = 1'b0;
            mph_nxt  = '0;
          end
        end
      end
    end
    oph_nxt = os_play_r ? oph_r + lsp_pkg::OPH_W'(cfg.os_step) : oph_r;
  end

  logic signed [11:0] mix_left, mix_right;

  lsp_mix u_mix (
    .main_a    (main_a_r),
    .main_b    (main_rdata),
    .main_frac (mph_r[31:20]),
    .main_on   (main_on_r),
    .os_a      (os_a_r),
    .os_b      (os_rdata),
    .os_frac   (oph_r[31:20]),
    .os_on     (os_play_r),
    .perf      (perf_nxt),
    .mix_left  (mix_left),
    .mix_right (mix_right)
  );

  // Sequencer and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mph_r     <= '0;
      oph_r     <= '0;
      os_act_r  <= 1'b0;
      os_play_r <= 1'b0;
      main_on_r <= 1'b0;
      perf_r    <= 1'b0;
      loops_r   <= lsp_pkg::LOOP_COUNT_RST;
      prev_sw_r <= lsp_pkg::SW_MID;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (tick_fire) begin
            perf_r    <= perf0;
            loops_r   <= loops0;
            mph_r     <= mph0;
            oph_r     <= oph0;
            os_act_r  <= os_play0;
            os_play_r <= os_play0;
            main_on_r <= (cfg.main_frames != '0);
            prev_sw_r <= sw;
            state_r   <= ST_RD_A;
          end
        end
        ST_RD_A: state_r <= ST_RD_B;
        ST_RD_B: state_r <= ST_DONE;
        ST_DONE: begin
          if (done_fire) begin
            mph_r   <= mph_nxt;
            loops_r <= loops_nxt;
            perf_r  <= perf_nxt;
            oph_r   <= oph_nxt;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // First frames of each voice
  always_ff @(posedge clk) begin
    if (state_r == ST_RD_B) begin
      main_a_r <= main_rdata;
      os_a_r   <= os_rdata;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      left_r      <= mix_left;
      right_r     <= mix_right;
      running_r   <= perf_nxt;
      loops_out_r <= loops_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.left_out   = left_r;
  assign out_ch.right_out  = right_r;
  assign out_ch.running    = running_r;
  assign out_ch.loops_left = loops_out_r;

endmodule
